// ===== hdl/lpcbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// LPC bus cycle decoder package
// Shared types and constants: sample and result words, decoder state and the
// one-hot phase encoding.
// ----------------------------------------------------------------------------
package lpcbcd_pkg;

  localparam int unsigned CntW = 4;

  localparam logic [3:0] START_TARGET   = 4'h0;
  localparam logic [3:0] START_FW_READ  = 4'hD;
  localparam logic [3:0] START_FW_WRITE = 4'hE;

  localparam logic [3:0] ALEN_IO  = 4'd4;
  localparam logic [3:0] ALEN_FW  = 4'd7;
  localparam logic [3:0] ALEN_MEM = 4'd8;

  localparam logic [8:0] SIZE_2   = 9'd2;
  localparam logic [8:0] SIZE_4   = 9'd4;
  localparam logic [8:0] SIZE_16  = 9'd16;
  localparam logic [8:0] SIZE_64  = 9'd64;
  localparam logic [8:0] SIZE_256 = 9'd256;

  localparam logic [3:0] MSIZE_2   = 4'd0;
  localparam logic [3:0] MSIZE_4   = 4'd1;
  localparam logic [3:0] MSIZE_16  = 4'd2;
  localparam logic [3:0] MSIZE_64  = 4'd4;
  localparam logic [3:0] MSIZE_256 = 4'd7;

  localparam logic [CntW-1:0] TAR_CLOCKS = 4'd2;

  typedef enum logic [8:0] {
    PH_IDLE  = 9'b000000001,
    PH_CTDIR = 9'b000000010,
    PH_IDSEL = 9'b000000100,
    PH_ADDR  = 9'b000001000,
    PH_MSIZE = 9'b000010000,
    PH_TAR   = 9'b000100000,
    PH_SYNC  = 9'b001000000,
    PH_DATA  = 9'b010000000,
    PH_ABORT = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic       frame_n;
    logic       clock_n;
    logic [3:0] lad;
  } sample_t;

  typedef struct packed {
    logic [3:0]  cycle_code;
    logic [3:0]  start_code;
    logic [31:0] address;
    logic [3:0]  address_nibbles;
    logic [7:0]  data_byte;
    logic [8:0]  size_nibbles;
    logic [3:0]  device_select;
    logic        aborted;
  } cycle_t;

  typedef struct packed {
    phase_e          phase;
    logic [3:0]      start;
    logic [3:0]      pending;
    logic            frame_seen_low;
    logic [2:0]      cyc_type;
    logic [3:0]      select;
    logic [31:0]     address;
    logic [7:0]      data;
    logic [CntW-1:0] count;
    logic [3:0]      addr_len;
    logic [8:0]      size_len;
    logic            prev_frame_n;
    logic            prev_clock_n;
  } state_t;

endpackage

// ===== hdl/lpcbcd_step.sv =====
// ----------------------------------------------------------------------------
// LPC bus cycle decoder step logic
// Computes the next decoder state and the optional decoded cycle for one
// bus sample.
// ----------------------------------------------------------------------------
module lpcbcd_step #(
  parameter int unsigned ABORT_SAMPLES = 5
) (
  input  lpcbcd_pkg::state_t  state_i,
  input  lpcbcd_pkg::sample_t sample_i,
  output lpcbcd_pkg::state_t  state_o,
  output logic                res_valid_o,
  output lpcbcd_pkg::cycle_t  res_o
);
  import lpcbcd_pkg::*;

  logic            skip;
  logic            fall;
  logic            rise;
  logic            run;
  logic            res_abort;
  logic [2:0]      pos;
  logic [CntW-1:0] cnt_inc;
  phase_e          ph;
  state_t          nx;

  always_comb begin
    nx          = state_i;
    res_valid_o = 1'b0;
    res_abort   = 1'b0;
    run         = 1'b0;
    rise        = 1'b0;
    ph          = state_i.phase;
    pos         = 3'(state_i.addr_len - 4'd1 - state_i.count);
    cnt_inc     = state_i.count + CntW'(1);
    skip        = sample_i.clock_n && !state_i.prev_clock_n;
    fall        = !sample_i.frame_n && state_i.prev_frame_n;

    nx.prev_clock_n = sample_i.clock_n;
    nx.prev_frame_n = sample_i.frame_n;

    if (!skip) begin
      rise = sample_i.frame_n && state_i.frame_seen_low;
      if (!sample_i.frame_n) begin
        nx.pending = sample_i.lad;
      end
      nx.frame_seen_low = !sample_i.frame_n;
      run = 1'b1;

      if (state_i.phase == PH_IDLE) begin
        run = 1'b0;
        if (rise) begin
          nx.start    = state_i.pending;
          nx.cyc_type = '0;
          nx.select   = '0;
          nx.address  = '0;
          nx.data     = '0;
          nx.count    = '0;
          nx.addr_len = '0;
          nx.size_len = SIZE_2;
          if (state_i.pending == START_TARGET) begin
            ph  = PH_CTDIR;
            run = 1'b1;
          end else if (state_i.pending == START_FW_READ ||
                       state_i.pending == START_FW_WRITE) begin
            ph  = PH_IDSEL;
            run = 1'b1;
          end
        end
      end else if (fall) begin
        ph       = PH_ABORT;
        nx.count = '0;
      end

      // Count increment from the value after a possible abort restart.
      cnt_inc = nx.count + CntW'(1);

      if (run) begin
        case (ph)
          PH_CTDIR: begin
            nx.cyc_type = sample_i.lad[3:1];
            nx.size_len = SIZE_2;
            nx.addr_len = (sample_i.lad[3:1] < 3'd2) ? ALEN_IO : ALEN_MEM;
            nx.count    = '0;
            ph          = PH_ADDR;
          end
          PH_IDSEL: begin
            nx.select   = sample_i.lad;
            nx.addr_len = ALEN_FW;
            nx.count    = '0;
            ph          = PH_ADDR;
          end
          PH_ADDR: begin
            nx.address = state_i.address | (32'(sample_i.lad) << {pos, 2'b00});
            nx.count   = cnt_inc;
            if (cnt_inc >= state_i.addr_len) begin
              nx.count = '0;
              if (state_i.start == START_TARGET) begin
                ph = state_i.cyc_type[0] ? PH_DATA : PH_TAR;
              end else begin
                ph = PH_MSIZE;
              end
            end
          end
          PH_MSIZE: begin
            nx.count = '0;
            ph = (state_i.start == START_FW_READ) ? PH_TAR : PH_DATA;
            case (sample_i.lad)
              MSIZE_2:   nx.size_len = SIZE_2;
              MSIZE_4:   nx.size_len = SIZE_4;
              MSIZE_16:  nx.size_len = SIZE_16;
              MSIZE_64:  nx.size_len = SIZE_64;
              MSIZE_256: nx.size_len = SIZE_256;
              default:   ph = PH_IDLE;
            endcase
          end
          PH_TAR: begin
            nx.count = cnt_inc;
            if (cnt_inc >= TAR_CLOCKS) begin
              nx.count = '0;
              ph       = PH_SYNC;
            end
          end
          PH_SYNC: begin
            if (sample_i.lad == 4'h0) begin
              nx.count = '0;
              nx.data  = '0;
              ph       = PH_DATA;
            end
          end
          PH_DATA: begin
            if (state_i.count == '0) begin
              nx.data  = {state_i.data[7:4], sample_i.lad};
              nx.count = CntW'(1);
            end else begin
              nx.data     = {sample_i.lad, state_i.data[3:0]};
              nx.count    = '0;
              ph          = PH_IDLE;
              res_valid_o = 1'b1;
            end
          end
          PH_ABORT: begin
            nx.count = cnt_inc;
            if (cnt_inc >= CntW'(ABORT_SAMPLES)) begin
              nx.count    = '0;
              ph          = PH_IDLE;
              res_valid_o = 1'b1;
              res_abort   = 1'b1;
            end
          end
          default: begin
            ph = PH_IDLE;
          end
        endcase
      end
      nx.phase = ph;
    end

    state_o = nx;

    res_o.cycle_code      = (nx.start == START_TARGET) ? {1'b0, nx.cyc_type} : nx.start;
    res_o.start_code      = nx.start;
    res_o.address         = nx.address;
    res_o.address_nibbles = nx.addr_len;
    res_o.data_byte       = nx.data;
    res_o.size_nibbles    = nx.size_len;
    res_o.device_select   = nx.select;
    res_o.aborted         = res_abort;
  end

endmodule

// ===== hdl/lpc_bus_cycle_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// LPC bus cycle decoder
// Watches sampled LFRAME#, LCLK and LAD and gives one word per decoded or
// aborted LPC bus cycle.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Word
//   -------  ---------  -------------------------  -----------------------------
//   in       input      in_valid_i / in_ready_o    lpcbcd_pkg::sample_t, a sample
//   out      output     out_valid_o / out_ready_i  lpcbcd_pkg::cycle_t, a cycle
//
// One sample word is taken per clock while the input stage is not held. A sample
// is held in the input register and is decoded on its way into the result
// register, from which the cycle word that the sample completes is given.
// Reset returns the decoder to idle with no cycle in progress and both
// registers empty.
// The input stage holds its word while the result register is full and not
// being taken; with out_ready_i high the block keeps up with one word a clock.
//
module lpc_bus_cycle_decoder_unit #(
  parameter int unsigned ABORT_SAMPLES = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lpcbcd_pkg::sample_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lpcbcd_pkg::cycle_t  out_data_o
);
  import lpcbcd_pkg::*;

  logic    in_valid_q;
  sample_t in_q;
  logic    out_valid_q;
  cycle_t  out_q;
  state_t  state_q;
  state_t  state_d;
  logic    res_valid;
  cycle_t  res;
  logic    advance;

  // The held sample moves on once the result register is free or being
  // emptied in this same cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  lpcbcd_step #(
    .ABORT_SAMPLES(ABORT_SAMPLES)
  ) u_step (
    .state_i    (state_q),
    .sample_i   (in_q),
    .state_o    (state_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // The decoder state is given defined reset values, as the model of the bus
  // cycle depends on them (for instance the previous LFRAME# level).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= PH_IDLE;
      state_q.start          <= '0;
      state_q.pending        <= '0;
      state_q.frame_seen_low <= 1'b0;
      state_q.cyc_type       <= '0;
      state_q.select         <= '0;
      state_q.address        <= '0;
      state_q.data           <= '0;
      state_q.count          <= '0;
      state_q.addr_len       <= '0;
      state_q.size_len       <= SIZE_2;
      state_q.prev_frame_n   <= 1'b1;
      state_q.prev_clock_n   <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A cycle word is only produced while collecting data or counting abort
  // samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |-> (state_q.phase == PH_DATA || state_q.phase == PH_ABORT))
    else $error("cycle word produced outside the data or abort phase");

  // A sample taken just after clock_n rose does not move the phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.clock_n && !state_q.prev_clock_n |=> state_q.phase == $past(state_q.phase))
    else $error("skipped sample changed the decoder phase");

  // The abort counter never holds the final count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_ABORT |-> state_q.count < CntW'(ABORT_SAMPLES))
    else $error("abort counter overran");

  // The aborted flag marks exactly the words that leave the abort phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |=> out_valid_q && out_q.aborted == $past(state_q.phase == PH_ABORT))
    else $error("aborted flag does not match the ending phase");
`endif

endmodule
